### design/pdlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlc_pkg: shared types and constants for the plug-and-play lookup block
// Request and result layouts, function, bus and status codes, and the
// sequencer state type.
// ----------------------------------------------------------------------------
package pdlc_pkg;

  // Default geometry
  localparam int SLOTS_DEF = 16;
  localparam int BARS_DEF  = 4;
  localparam int BUS_COUNT = 3;

  // Bank word decode constants
  localparam logic [31:0] APB_WINDOW     = 32'h8000_0000;
  localparam logic [31:0] AHB_START_MASK = 32'hFFF0_0000;

  // Function codes
  localparam logic [1:0] FUNC_LOAD_ID   = 2'd0;
  localparam logic [1:0] FUNC_LOAD_BANK = 2'd1;
  localparam logic [1:0] FUNC_CAPTURE   = 2'd2;

  // Bus codes
  localparam logic [1:0] BUS_APB     = 2'd0;
  localparam logic [1:0] BUS_AHB_SLV = 2'd1;
  localparam logic [1:0] BUS_AHB_MST = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_OWNED     = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  bus;
    logic [3:0]  slot_index;
    logic [1:0]  bar_index;
    logic [31:0] word;
    logic [7:0]  vendor_id;
    logic [11:0] device_id;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_slot;
    logic [4:0]  irq_line;
    logic [4:0]  core_version;
    logic        bar_used;
    logic [31:0] bar_start;
    logic [11:0] bar_mask;
    logic [3:0]  bar_type;
    logic        prefetchable;
    logic        cacheable;
    logic        last;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_BANK,
    ST_EMIT
  } state_t;

endpackage

### design/pdlc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/pnp_device_lookup_and_claim_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnp_device_lookup_and_claim_top: plug-and-play device lookup and claim
// Id and bank word tables for APB, AHB slave and AHB master, with a walk
// over the slots of one bus to find and claim a device.
// ----------------------------------------------------------------------------
// After reset the block sweeps both word memories to zero, one entry a cycle,
// over all SLOTS*(1+2*BARS) bank entries (144 with the defaults), and takes
// no request until that is done. A load request writes its word as it is
// taken. A capture request walks the id memory of the named bus through a
// single comparator, one slot a cycle with the memory read one slot ahead;
// a bus code out of range skips the walk. A hit then goes through the
// ownership check and, for each result, a bank memory read and then the
// hand-over to the output register. The next request is taken once the last
// result has been placed in the output register.
module pnp_device_lookup_and_claim_top #(
  parameter int SLOTS = pdlc_pkg::SLOTS_DEF,
  parameter int BARS  = pdlc_pkg::BARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdlc_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pdlc_pkg::out_rsp_t out_data
);

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BAR_W    = (BARS > 1) ? $clog2(BARS) : 1;
  localparam int ID_DEPTH = pdlc_pkg::BUS_COUNT * SLOTS;
  localparam int BK_DEPTH = SLOTS * (1 + 2 * BARS);
  localparam int ID_AW    = $clog2(ID_DEPTH);
  localparam int BK_AW    = $clog2(BK_DEPTH);

  pdlc_pkg::state_t state, state_next;

  logic                 clearing;
  logic [BK_AW-1:0]     clr_cnt;
  logic [1:0]           cur_bus;
  logic [7:0]           cur_vendor;
  logic [11:0]          cur_device;
  logic [SLOT_W:0]      scan_idx, scan_idx_next;
  logic                 pend, pend_next;
  logic [SLOT_W-1:0]    cmp_slot, cmp_slot_next;
  logic [SLOT_W-1:0]    found, found_next;
  logic [31:0]          id_q, id_next;
  logic [BAR_W-1:0]     bar_q, bar_next;
  pdlc_pkg::out_rsp_t   res, res_next;
  pdlc_pkg::out_rsp_t   out_q;
  logic [SLOTS-1:0]     owned [pdlc_pkg::BUS_COUNT];

  logic                 in_accept, cap_accept, load_id, load_bank;
  logic                 out_free, id_match, scan_last, owned_hit, claim;
  logic                 id_re, bk_re, id_we, bk_we;
  logic [BAR_W-1:0]     bk_bar;
  logic [ID_AW-1:0]     id_raddr, id_waddr;
  logic [BK_AW-1:0]     bk_raddr, bk_waddr;
  logic [31:0]          id_rdata, bk_rdata, wdata;

  // Bank memory layout: APB slots, then AHB slave rows, then AHB master rows
  function automatic logic [BK_AW-1:0] bank_addr(input logic [1:0] bus,
                                                 input logic [BK_AW-1:0] slot,
                                                 input logic [BK_AW-1:0] bar);
    logic [BK_AW-1:0] base;
    base = (bus == pdlc_pkg::BUS_AHB_SLV) ? BK_AW'(SLOTS) : BK_AW'(SLOTS + SLOTS * BARS);
    if (bus == pdlc_pkg::BUS_APB) begin
      return slot;
    end
    return base + slot * BK_AW'(BARS) + bar;
  endfunction

  // Handshake decode
  assign in_ready   = (state == pdlc_pkg::ST_IDLE) && !clearing;
  assign in_accept  = in_valid && in_ready;
  assign cap_accept = in_accept && (in_data.func == pdlc_pkg::FUNC_CAPTURE);
  assign load_id    = in_accept && (in_data.func == pdlc_pkg::FUNC_LOAD_ID) &&
                      (in_data.bus < 2'(pdlc_pkg::BUS_COUNT)) &&
                      (7'(in_data.slot_index) < 7'(SLOTS));
  assign load_bank  = in_accept && (in_data.func == pdlc_pkg::FUNC_LOAD_BANK) &&
                      (in_data.bus < 2'(pdlc_pkg::BUS_COUNT)) &&
                      (7'(in_data.slot_index) < 7'(SLOTS)) &&
                      ((in_data.bus == pdlc_pkg::BUS_APB) ? (in_data.bar_index == 2'd0)
                                                          : (3'(in_data.bar_index) < 3'(BARS)));
  assign out_free   = !out_valid || out_ready;
  assign out_data   = out_q;

  // Shared comparator and ownership lookup
  assign id_match  = (id_rdata[31:24] == cur_vendor) && (id_rdata[23:12] == cur_device);
  assign scan_last = (cmp_slot == SLOT_W'(SLOTS - 1));
  assign owned_hit = owned[cur_bus][found];

  // Memory write port: clearing sweep or load request
  assign wdata    = clearing ? 32'd0 : in_data.word;
  assign id_we    = clearing ? ((BK_AW + 1)'(clr_cnt) < (BK_AW + 1)'(ID_DEPTH)) : load_id;
  assign bk_we    = clearing || load_bank;
  assign id_waddr = clearing ? ID_AW'(clr_cnt)
                             : ID_AW'(in_data.bus) * ID_AW'(SLOTS) + ID_AW'(in_data.slot_index);
  assign bk_waddr = clearing ? clr_cnt
                             : bank_addr(in_data.bus, BK_AW'(in_data.slot_index),
                                         BK_AW'(in_data.bar_index));

  // Memory read addresses
  assign id_raddr = ID_AW'(cur_bus) * ID_AW'(SLOTS) + ID_AW'(scan_idx[SLOT_W-1:0]);
  assign bk_raddr = bank_addr(cur_bus, BK_AW'(found), BK_AW'(bk_bar));

  pdlc_ram #(.WIDTH(32), .DEPTH(ID_DEPTH)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (wdata),
    .re    (id_re),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  pdlc_ram #(.WIDTH(32), .DEPTH(BK_DEPTH)) u_bank_ram (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (wdata),
    .re    (bk_re),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pdlc_pkg::ST_IDLE: begin
        if (cap_accept) begin
          state_next = (in_data.bus < 2'(pdlc_pkg::BUS_COUNT)) ? pdlc_pkg::ST_SCAN
                                                               : pdlc_pkg::ST_EMIT;
        end
      end
      pdlc_pkg::ST_SCAN: begin
        if (pend && id_match) begin
          state_next = pdlc_pkg::ST_CHECK;
        end else if (pend && scan_last) begin
          state_next = pdlc_pkg::ST_EMIT;
        end
      end
      pdlc_pkg::ST_CHECK: begin
        state_next = owned_hit ? pdlc_pkg::ST_EMIT : pdlc_pkg::ST_BANK;
      end
      pdlc_pkg::ST_BANK: begin
        state_next = pdlc_pkg::ST_EMIT;
      end
      pdlc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = res.last ? pdlc_pkg::ST_IDLE : pdlc_pkg::ST_BANK;
        end
      end
      default: state_next = pdlc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs and datapath next values
  always_comb begin
    scan_idx_next = scan_idx;
    pend_next     = pend;
    cmp_slot_next = cmp_slot;
    found_next    = found;
    id_next       = id_q;
    bar_next      = bar_q;
    res_next      = res;
    claim         = 1'b0;
    id_re         = 1'b0;
    bk_re         = 1'b0;
    bk_bar        = bar_q;
    unique case (state)
      pdlc_pkg::ST_IDLE: begin
        if (cap_accept) begin
          scan_idx_next       = '0;
          pend_next           = 1'b0;
          res_next            = '0;
          res_next.status     = pdlc_pkg::STATUS_NOT_FOUND;
          res_next.last       = 1'b1;
        end
      end
      pdlc_pkg::ST_SCAN: begin
        // Read one slot ahead while comparing the previous one
        id_re = (scan_idx < (SLOT_W + 1)'(SLOTS));
        if (id_re) begin
          scan_idx_next = scan_idx + 1'b1;
        end
        cmp_slot_next = scan_idx[SLOT_W-1:0];
        pend_next     = id_re;
        if (pend && id_match) begin
          found_next = cmp_slot;
          id_next    = id_rdata;
        end else if (pend && scan_last) begin
          res_next        = '0;
          res_next.status = pdlc_pkg::STATUS_NOT_FOUND;
          res_next.last   = 1'b1;
        end
      end
      pdlc_pkg::ST_CHECK: begin
        if (owned_hit) begin
          res_next            = '0;
          res_next.status     = pdlc_pkg::STATUS_OWNED;
          res_next.found_slot = 4'(found);
          res_next.last       = 1'b1;
        end else begin
          claim    = 1'b1;
          bk_re    = 1'b1;
          bk_bar   = '0;
          bar_next = '0;
        end
      end
      pdlc_pkg::ST_BANK: begin
        // Decode the bank word just read
        res_next              = '0;
        res_next.status       = pdlc_pkg::STATUS_OK;
        res_next.found_slot   = 4'(found);
        res_next.irq_line     = id_q[4:0];
        res_next.core_version = id_q[9:5];
        if (cur_bus == pdlc_pkg::BUS_APB) begin
          res_next.bar_used  = 1'b1;
          res_next.bar_start = pdlc_pkg::APB_WINDOW |
                               32'({bk_rdata[31:20] & bk_rdata[15:4], 8'h00});
          res_next.bar_mask  = bk_rdata[15:4];
          res_next.bar_type  = bk_rdata[3:0];
          res_next.last      = 1'b1;
        end else begin
          if (bk_rdata != 32'd0) begin
            res_next.bar_used     = 1'b1;
            res_next.bar_start    = bk_rdata & pdlc_pkg::AHB_START_MASK;
            res_next.bar_mask     = bk_rdata[15:4];
            res_next.bar_type     = bk_rdata[3:0];
            res_next.prefetchable = bk_rdata[17];
            res_next.cacheable    = bk_rdata[16];
          end
          res_next.last = (bar_q == BAR_W'(BARS - 1));
        end
      end
      pdlc_pkg::ST_EMIT: begin
        // Advance to the next bank once this result is handed over
        if (out_free && !res.last) begin
          bar_next = bar_q + 1'b1;
          bk_re    = 1'b1;
          bk_bar   = bar_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pdlc_pkg::ST_IDLE;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      for (int b = 0; b < pdlc_pkg::BUS_COUNT; b++) begin
        owned[b] <= '0;
      end
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == BK_AW'(BK_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (claim) begin
        owned[cur_bus][found] <= 1'b1;
      end
      if (state == pdlc_pkg::ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cap_accept) begin
      cur_bus    <= in_data.bus;
      cur_vendor <= in_data.vendor_id;
      cur_device <= in_data.device_id;
    end
    scan_idx <= scan_idx_next;
    cmp_slot <= cmp_slot_next;
    found    <= found_next;
    id_q     <= id_next;
    bar_q    <= bar_next;
    res      <= res_next;
    if (state == pdlc_pkg::ST_EMIT && out_free) begin
      out_q <= res;
    end
  end

  // A refusal or a miss is always a single, final result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != pdlc_pkg::STATUS_OK) |-> out_data.last)
    else $error("non-claim result not marked last");

  // A free slot found by the walk goes on to read its banks
  assert property (@(posedge clk) disable iff (rst)
    (state == pdlc_pkg::ST_CHECK && !owned_hit) |=> (state == pdlc_pkg::ST_BANK))
    else $error("claimed slot did not proceed to bank read");

  // Each hand-over of a non-final result steps to the next bank
  assert property (@(posedge clk) disable iff (rst)
    (state == pdlc_pkg::ST_EMIT && out_free && !res.last) |=>
      (state == pdlc_pkg::ST_BANK && bar_q == $past(bar_q) + 1'b1))
    else $error("bank index did not advance");

  // No request is taken during the clearing sweep
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("request accepted while clearing");

endmodule
